### rtl/core/spfa_pkg.sv
package spfa_pkg;

  // field widths
  localparam int ACC_W   = 10;
  localparam int SPEED_W = 11;
  localparam int POS_W   = 7;

  // scan window and default averaging depth
  localparam logic [POS_W-1:0] SCAN_LIMIT = 7'd73;
  localparam int AVG_LEN_DEFAULT = 5;

  // threshold after reset
  localparam logic [SPEED_W-1:0] THRESHOLD_RESET = 11'd50;

  // characters of interest
  localparam logic [7:0] CHAR_W    = 8'h57;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // knots to mph: floor(v * 1.15076) as (v * CONV_MULT) >> CONV_SHIFT, exact for v < 1000
  localparam int CONV_SHIFT = 25;
  localparam int CONV_MULT_W = 26;
  localparam logic [CONV_MULT_W-1:0] CONV_MULT = 26'd38613099;
  localparam int CONV_PROD_W = ACC_W + CONV_MULT_W;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_SLOW = 2'd1,
    MODE_FAST = 2'd2
  } disp_mode_t;

  // parsed field handed from the parser
  typedef struct packed {
    logic             found;
    disp_mode_t       mode;
    logic [ACC_W-1:0] acc;
  } reading_t;

  // converted reading handed to the averager
  typedef struct packed {
    logic               found;
    disp_mode_t         mode;
    logic [SPEED_W-1:0] speed;
  } conv_t;

  // ascii digit value, non-digits count as zero
  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [7:0] diff;
    diff = c - CHAR_ZERO;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      return diff[3:0];
    end
    return 4'd0;
  endfunction

endpackage

### rtl/core/spfa_parser.sv
module spfa_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              sentence_start,
  input  logic [7:0]        char_byte,
  output logic              rd_valid,
  input  logic              rd_ready,
  output spfa_pkg::reading_t rd
);
  import spfa_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SCAN,
    PH_SKIP,
    PH_HUND,
    PH_TENS_OR_PT,
    PH_TENS,
    PH_ONES_OR_PT,
    PH_ONES
  } phase_t;

  phase_t           phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [ACC_W-1:0] acc, acc_next;
  logic             slow_flag, slow_flag_next;
  logic             fast_pend, fast_pend_next;
  logic             emit;
  reading_t         emit_rd;
  logic             accept;
  logic [ACC_W-1:0] digit_ext;

  // input taken whenever the output slot is free or draining
  assign in_stall  = rd_valid && !rd_ready;
  assign accept    = in_valid && !in_stall;
  assign digit_ext = ACC_W'(digit_of(char_byte));

  // next parse state for the current byte
  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    acc_next       = acc;
    slow_flag_next = slow_flag;
    fast_pend_next = fast_pend;
    emit           = 1'b0;
    emit_rd.found  = 1'b0;
    emit_rd.mode   = MODE_NONE;
    emit_rd.acc    = acc;
    if (sentence_start) begin
      phase_next     = PH_SCAN;
      pos_next       = '0;
      acc_next       = '0;
      slow_flag_next = 1'b0;
    end else begin
      case (phase)
        PH_SCAN: begin
          pos_next = pos + 1'b1;
          if (char_byte == CHAR_W) begin
            phase_next = PH_SKIP;
          end else if (pos_next >= SCAN_LIMIT) begin
            // no speed field in the window
            phase_next = PH_IDLE;
            emit       = 1'b1;
          end
        end
        PH_SKIP: begin
          phase_next = PH_HUND;
        end
        PH_HUND: begin
          acc_next   = digit_ext * ACC_W'(100);
          phase_next = PH_TENS_OR_PT;
        end
        PH_TENS_OR_PT: begin
          if (char_byte == CHAR_DOT) begin
            slow_flag_next = 1'b1;
            phase_next     = PH_TENS;
          end else begin
            acc_next   = acc + digit_ext * ACC_W'(10);
            phase_next = PH_ONES_OR_PT;
          end
        end
        PH_TENS: begin
          acc_next   = acc + digit_ext * ACC_W'(10);
          phase_next = PH_ONES_OR_PT;
        end
        PH_ONES_OR_PT, PH_ONES: begin
          if (phase == PH_ONES_OR_PT && char_byte == CHAR_DOT) begin
            fast_pend_next = 1'b1;
            phase_next     = PH_ONES;
          end else begin
            // field complete, settle the display mode
            acc_next      = acc + digit_ext;
            emit          = 1'b1;
            emit_rd.found = 1'b1;
            emit_rd.acc   = acc + digit_ext;
            phase_next    = PH_IDLE;
            if (slow_flag) begin
              emit_rd.mode   = MODE_SLOW;
              slow_flag_next = 1'b0;
            end else if (fast_pend) begin
              emit_rd.mode   = MODE_FAST;
              fast_pend_next = 1'b0;
            end
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // parse state and output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      pos       <= '0;
      acc       <= '0;
      slow_flag <= 1'b0;
      fast_pend <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase     <= phase_next;
        pos       <= pos_next;
        acc       <= acc_next;
        slow_flag <= slow_flag_next;
        fast_pend <= fast_pend_next;
      end
      if (accept && emit) begin
        rd_valid <= 1'b1;
        rd       <= emit_rd;
      end else if (rd_ready) begin
        rd_valid <= 1'b0;
      end
    end
  end

  // a miss never carries a display mode
  a_miss_no_mode: assert property (@(posedge clk) disable iff (rst)
    rd_valid && !rd.found |-> rd.mode == MODE_NONE)
    else $error("miss item with display mode");

  // a parsed value never exceeds three digits
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> rd.acc <= ACC_W'(999))
    else $error("parsed value out of range");

  // a full slot holds while the next stage is busy
  a_slot_hold: assert property (@(posedge clk) disable iff (rst)
    rd_valid && !rd_ready |=> rd_valid && $stable(rd))
    else $error("parsed item lost under stall");

endmodule

### rtl/core/spfa_convert.sv
module spfa_convert (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_valid,
  output logic               rd_ready,
  input  spfa_pkg::reading_t rd,
  output logic               cv_valid,
  input  logic               cv_ready,
  output spfa_pkg::conv_t    cv
);
  import spfa_pkg::*;

  logic [CONV_PROD_W-1:0] prod;
  logic                   load;

  // knots to mph by reciprocal multiply
  assign prod     = CONV_PROD_W'(rd.acc) * CONV_PROD_W'(CONV_MULT);
  assign rd_ready = !cv_valid || cv_ready;
  assign load     = rd_valid && rd_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cv_valid <= 1'b0;
    end else if (rd_ready) begin
      cv_valid <= rd_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (load) begin
      cv.found <= rd.found;
      cv.mode  <= rd.mode;
      cv.speed <= prod[CONV_SHIFT +: SPEED_W];
    end
  end

  // converted speed stays within the display range
  a_conv_range: assert property (@(posedge clk) disable iff (rst)
    cv_valid && cv.found |-> cv.speed <= SPEED_W'(1149))
    else $error("converted speed out of range");

  // a waiting item is not dropped
  a_cv_hold: assert property (@(posedge clk) disable iff (rst)
    cv_valid && !cv_ready |=> cv_valid && $stable(cv))
    else $error("converted item lost under stall");

  // the stage takes an item whenever it has room
  a_cv_take: assert property (@(posedge clk) disable iff (rst)
    rd_valid && !cv_valid |=> cv_valid)
    else $error("converter missed an item");

endmodule

### rtl/core/spfa_average.sv
module spfa_average #(
  parameter int AVG_LEN = spfa_pkg::AVG_LEN_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cv_valid,
  output logic                         cv_ready,
  input  spfa_pkg::conv_t              cv,
  input  logic [spfa_pkg::SPEED_W-1:0] threshold,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         speed_found,
  output logic [1:0]                   display_mode,
  output logic [spfa_pkg::SPEED_W-1:0] shown_value
);
  import spfa_pkg::*;

  localparam int HIST_N      = AVG_LEN - 1;
  localparam int SUM_W       = $clog2(AVG_LEN * (2 ** SPEED_W));
  localparam int RECIP_SHIFT = SUM_W + $clog2(AVG_LEN);
  localparam int RECIP       = (2 ** RECIP_SHIFT + AVG_LEN - 1) / AVG_LEN;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  logic [SPEED_W-1:0] hist [HIST_N];
  logic [SUM_W-1:0]   sum;
  logic [PROD_W-1:0]  prod;
  logic [SPEED_W-1:0] avg;
  logic [SPEED_W-1:0] shown;
  logic               load;

  assign cv_ready = !out_valid || !out_stall;
  assign load     = cv_valid && cv_ready;

  // window sum, newest reading plus the stored ones
  always_comb begin
    sum = SUM_W'(cv.speed);
    for (int i = 0; i < HIST_N; i++) begin
      sum = sum + SUM_W'(hist[i]);
    end
  end

  // divide by window length through a reciprocal
  assign prod = PROD_W'(sum) * PROD_W'(RECIP);
  assign avg  = prod[RECIP_SHIFT +: SPEED_W];

  // shown value by display mode
  always_comb begin
    case (cv.mode)
      MODE_SLOW: shown = (avg <= threshold) ? '0 : avg;
      MODE_FAST: shown = avg;
      default:   shown = '0;
    endcase
  end

  // reading history, newest first
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_N; i++) begin
        hist[i] <= '0;
      end
    end else if (load && cv.found) begin
      hist[0] <= cv.speed;
      for (int i = 1; i < HIST_N; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cv_ready) begin
      out_valid <= cv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      speed_found  <= cv.found;
      display_mode <= cv.mode;
      shown_value  <= shown;
    end
  end

  // a miss shows nothing
  a_miss_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && !speed_found |-> display_mode == MODE_NONE && shown_value == '0)
    else $error("miss item shows a value");

  // history moves only with a parsed reading
  a_hist_stable: assert property (@(posedge clk) disable iff (rst)
    !rst && !(load && cv.found) |=> $stable(hist[0]))
    else $error("history changed without a reading");

  // the newest reading enters the history
  a_hist_push: assert property (@(posedge clk) disable iff (rst)
    !rst && load && cv.found |=> hist[0] == $past(cv.speed))
    else $error("history missed a reading");

endmodule

### rtl/core/gps_speed_field_parser_averager_core.sv
// channel   | handshake                     | payload
// ----------+-------------------------------+------------------------------------------
// in        | in_valid / in_stall           | sentence_start, char_byte
// out       | out_valid / out_stall         | speed_found, display_mode, shown_value
// cfg       | cfg_valid / cfg_ready         | cfg_data (slow display zero threshold)
//
// one byte per cycle while in_stall is low; parse, multiply, average stages are registered
// a result moves through the parser slot, the converter register and the output register
// in_stall rises only when all three stages hold results and out_stall is high
// synchronous reset clears parse state, stage valids and history; threshold returns to 50
// cfg_ready is always high, a write lands at the edge it is presented
module gps_speed_field_parser_averager_core #(
  parameter int AVG_LEN = spfa_pkg::AVG_LEN_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         sentence_start,
  input  logic [7:0]                   char_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         speed_found,
  output logic [1:0]                   display_mode,
  output logic [spfa_pkg::SPEED_W-1:0] shown_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [spfa_pkg::SPEED_W-1:0] cfg_data
);
  import spfa_pkg::*;

  logic               rd_valid;
  logic               rd_ready;
  reading_t           rd;
  logic               cv_valid;
  logic               cv_ready;
  conv_t              cv;
  logic [SPEED_W-1:0] threshold;

  // threshold register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  // sentence parser
  spfa_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sentence_start (sentence_start),
    .char_byte      (char_byte),
    .rd_valid       (rd_valid),
    .rd_ready       (rd_ready),
    .rd             (rd)
  );

  // unit conversion
  spfa_convert u_convert (
    .clk      (clk),
    .rst      (rst),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd       (rd),
    .cv_valid (cv_valid),
    .cv_ready (cv_ready),
    .cv       (cv)
  );

  // moving average and display select
  spfa_average #(
    .AVG_LEN (AVG_LEN)
  ) u_average (
    .clk          (clk),
    .rst          (rst),
    .cv_valid     (cv_valid),
    .cv_ready     (cv_ready),
    .cv           (cv),
    .threshold    (threshold),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .speed_found  (speed_found),
    .display_mode (display_mode),
    .shown_value  (shown_value)
  );

endmodule
